// ----- rtl/apcr_pkg.sv -----
// Shared constants, types and codes of the allpass cascade reverb.
`timescale 1ns / 1ps

package apcr_pkg;

    // Sizing of the delay store
    localparam int MAX_STAGES   = 8;
    localparam int MAX_DELAY    = 2048;
    localparam int MAX_CHANNELS = 2;
    localparam int SAMPLE_BITS  = 16;

    localparam int STAGE_W = $clog2(MAX_STAGES);
    localparam int POS_W   = $clog2(MAX_DELAY);
    localparam int CH_W    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int ADDR_W  = STAGE_W + CH_W + POS_W;
    localparam int MEM_DEPTH = 1 << ADDR_W;

    // Field and register widths
    localparam int WORD_W  = 24;
    localparam int OUT_W   = 32;
    localparam int DELAY_W = 12;
    localparam int SCNT_W  = 4;
    localparam int GAIN_W  = 15;
    localparam int OGAIN_W = 16;
    localparam int CCNT_W  = 2;
    localparam int CFG_W   = 16;
    localparam int IDX_W   = 3;

    // Fixed-point datapath widths
    localparam int FRAC_W  = 15;
    localparam int C_W     = FRAC_W + 1;
    localparam int MUL_A_W = 25;
    localparam int MUL_B_W = 18;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int SUM_W   = 40;
    localparam int SPLIT_W = 20;
    localparam int ACC_W   = 57;
    localparam int OSHIFT  = 8;

    // Register reset values
    localparam logic [DELAY_W-1:0] DELAY_RST  = DELAY_W'(1102);
    localparam logic [SCNT_W-1:0]  STAGES_RST = SCNT_W'(5);
    localparam logic [GAIN_W-1:0]  DECAY_RST  = GAIN_W'(26214);
    localparam logic [OGAIN_W-1:0] OGAIN_RST  = OGAIN_W'(512);
    localparam logic [CCNT_W-1:0]  CHANS_RST  = CCNT_W'(1);

    typedef logic signed [WORD_W-1:0] word_t;

    typedef enum logic [IDX_W-1:0] {
        REG_DELAY    = 3'd0,
        REG_STAGES   = 3'd1,
        REG_DECAY    = 3'd2,
        REG_OGAIN    = 3'd3,
        REG_CHANNELS = 3'd4
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD,
        ST_BASE,
        ST_GY,
        ST_SUM,
        ST_CLO,
        ST_CHI,
        ST_ACC,
        ST_WR,
        ST_OMUL,
        ST_ODONE
    } state_t;

    typedef enum logic [2:0] {
        MUL_GG,
        MUL_GY,
        MUL_GX,
        MUL_CLO,
        MUL_CHI,
        MUL_OUT
    } mul_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD_NGX,
        ACC_ADD_LO,
        ACC_ADD_HI
    } acc_op_t;

    typedef enum logic [1:0] {
        WSEL_ZERO,
        WSEL_SAMPLE,
        WSEL_STAGE
    } wsel_t;

    // Datapath controls driven by the sequencer
    typedef struct packed {
        logic     mul_en;
        mul_sel_t mul_sel;
        acc_op_t  acc_op;
        logic     ld_sample;
        logic     ld_base;
        logic     ld_yd;
        logic     ld_s;
        logic     ld_stage;
        logic     ld_out;
        wsel_t    wsel;
    } dp_ctl_t;

endpackage

// ----- rtl/apcr_delay_mem.sv -----
// Single-port-write, single-port-read delay store with registered read data.
`timescale 1ns / 1ps

module apcr_delay_mem
(
    input  logic                       clk,
    input  logic                       we,
    input  logic [apcr_pkg::ADDR_W-1:0] waddr,
    input  apcr_pkg::word_t            wdata,
    input  logic                       re,
    input  logic [apcr_pkg::ADDR_W-1:0] raddr,
    output apcr_pkg::word_t            rdata
);

    apcr_pkg::word_t mem_reg [apcr_pkg::MEM_DEPTH];
    apcr_pkg::word_t rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Read port, registered
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/apcr_dp.sv -----
// Shared multiply-accumulate datapath: stage arithmetic and output scaling.
`timescale 1ns / 1ps

module apcr_dp
(
    input  logic                               clk,
    input  apcr_pkg::dp_ctl_t                  ctl,
    input  logic signed [apcr_pkg::SAMPLE_BITS-1:0] sample_in,
    input  logic [apcr_pkg::GAIN_W-1:0]        decay_gain,
    input  logic [apcr_pkg::OGAIN_W-1:0]       output_gain,
    input  apcr_pkg::word_t                    rdata,
    output apcr_pkg::word_t                    wdata,
    output logic signed [apcr_pkg::OUT_W-1:0]  sample_out
);

    localparam int Q_W   = apcr_pkg::ACC_W - 2 * apcr_pkg::FRAC_W + 1;
    localparam int OQ_W  = apcr_pkg::PROD_W - apcr_pkg::OSHIFT + 1;
    localparam int CD_W  = 2 * apcr_pkg::FRAC_W + 1;
    localparam longint WORD_HI = (longint'(1) << (apcr_pkg::WORD_W - 1)) - 1;
    localparam longint WORD_LO = -WORD_HI - 1;
    localparam longint OUT_HI  = (longint'(1) << (apcr_pkg::OUT_W - 1)) - 1;
    localparam longint OUT_LO  = -OUT_HI - 1;
    localparam logic signed [Q_W-1:0]  Y_HI = Q_W'(WORD_HI);
    localparam logic signed [Q_W-1:0]  Y_LO = Q_W'(WORD_LO);
    localparam logic signed [OQ_W-1:0] O_HI = OQ_W'(OUT_HI);
    localparam logic signed [OQ_W-1:0] O_LO = OQ_W'(OUT_LO);

    apcr_pkg::word_t                          x_reg;
    apcr_pkg::word_t                          xd_reg;
    apcr_pkg::word_t                          yd_reg;
    logic [apcr_pkg::C_W-1:0]                 c_reg;
    logic signed [apcr_pkg::SUM_W-1:0]        s_reg;
    logic signed [apcr_pkg::ACC_W-1:0]        acc_reg;
    logic signed [apcr_pkg::ACC_W-1:0]        acc_next;
    logic signed [apcr_pkg::PROD_W-1:0]       prod_reg;
    logic signed [apcr_pkg::PROD_W-1:0]       prod_next;
    logic signed [apcr_pkg::OUT_W-1:0]        out_reg;

    logic signed [apcr_pkg::MUL_A_W-1:0]      mul_a;
    logic signed [apcr_pkg::MUL_B_W-1:0]      mul_b;
    logic signed [apcr_pkg::MUL_B_W-1:0]      gain_b;
    logic signed [apcr_pkg::SUM_W-1:0]        s_next;
    logic [CD_W-1:0]                          c_diff;
    logic [apcr_pkg::C_W-1:0]                 c_next;
    logic                                     y_adj;
    logic signed [Q_W-1:0]                    y_quot;
    apcr_pkg::word_t                          y_sat;
    logic                                     o_adj;
    logic signed [OQ_W-1:0]                   o_quot;
    logic signed [apcr_pkg::OUT_W-1:0]        o_sat;

    assign gain_b = $signed({{(apcr_pkg::MUL_B_W - apcr_pkg::GAIN_W){1'b0}}, decay_gain});

    // Select multiplier operands
    always_comb
    begin
        case (ctl.mul_sel)
            apcr_pkg::MUL_GG:
            begin
                mul_a = $signed({{(apcr_pkg::MUL_A_W - apcr_pkg::GAIN_W){1'b0}}, decay_gain});
                mul_b = gain_b;
            end
            apcr_pkg::MUL_GY:
            begin
                mul_a = apcr_pkg::MUL_A_W'(rdata);
                mul_b = gain_b;
            end
            apcr_pkg::MUL_GX:
            begin
                mul_a = apcr_pkg::MUL_A_W'(x_reg);
                mul_b = gain_b;
            end
            apcr_pkg::MUL_CLO:
            begin
                mul_a = $signed({{(apcr_pkg::MUL_A_W - apcr_pkg::SPLIT_W){1'b0}},
                                 s_reg[apcr_pkg::SPLIT_W-1:0]});
                mul_b = $signed({{(apcr_pkg::MUL_B_W - apcr_pkg::C_W){1'b0}}, c_reg});
            end
            apcr_pkg::MUL_CHI:
            begin
                mul_a = apcr_pkg::MUL_A_W'($signed(s_reg[apcr_pkg::SUM_W-1:apcr_pkg::SPLIT_W]));
                mul_b = $signed({{(apcr_pkg::MUL_B_W - apcr_pkg::C_W){1'b0}}, c_reg});
            end
            apcr_pkg::MUL_OUT:
            begin
                mul_a = apcr_pkg::MUL_A_W'(x_reg);
                mul_b = $signed({{(apcr_pkg::MUL_B_W - apcr_pkg::OGAIN_W){1'b0}}, output_gain});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // Coefficient 1-g^2: (2^30 - G*G) >> 15
    assign c_diff = (CD_W'(1) << (2 * apcr_pkg::FRAC_W))
                  - {1'b0, prod_reg[2*apcr_pkg::FRAC_W-1:0]};
    assign c_next = c_diff[CD_W-1:apcr_pkg::FRAC_W];

    // Partial sum xd*2^15 + G*yd
    assign s_next = (apcr_pkg::SUM_W'(xd_reg) <<< apcr_pkg::FRAC_W)
                  + apcr_pkg::SUM_W'(prod_reg);

    // Accumulate C*S - G*x*2^15 from partial products
    always_comb
    begin
        case (ctl.acc_op)
            apcr_pkg::ACC_LOAD_NGX:
                acc_next = -(apcr_pkg::ACC_W'(prod_reg) <<< apcr_pkg::FRAC_W);
            apcr_pkg::ACC_ADD_LO:
                acc_next = acc_reg + apcr_pkg::ACC_W'(prod_reg);
            apcr_pkg::ACC_ADD_HI:
                acc_next = acc_reg + (apcr_pkg::ACC_W'(prod_reg) <<< apcr_pkg::SPLIT_W);
            default:
                acc_next = acc_reg;
        endcase
    end

    // Divide by 2^30 toward zero and saturate to the stage word
    assign y_adj  = acc_reg[apcr_pkg::ACC_W-1] & (|acc_reg[2*apcr_pkg::FRAC_W-1:0]);
    assign y_quot = $signed({acc_reg[apcr_pkg::ACC_W-1],
                             acc_reg[apcr_pkg::ACC_W-1:2*apcr_pkg::FRAC_W]})
                  + $signed({{(Q_W-1){1'b0}}, y_adj});

    always_comb
    begin
        if (y_quot > Y_HI)
        begin
            y_sat = Y_HI[apcr_pkg::WORD_W-1:0];
        end
        else if (y_quot < Y_LO)
        begin
            y_sat = Y_LO[apcr_pkg::WORD_W-1:0];
        end
        else
        begin
            y_sat = y_quot[apcr_pkg::WORD_W-1:0];
        end
    end

    // Divide the scaled output by 2^8 toward zero and saturate
    assign o_adj  = prod_reg[apcr_pkg::PROD_W-1] & (|prod_reg[apcr_pkg::OSHIFT-1:0]);
    assign o_quot = $signed({prod_reg[apcr_pkg::PROD_W-1],
                             prod_reg[apcr_pkg::PROD_W-1:apcr_pkg::OSHIFT]})
                  + $signed({{(OQ_W-1){1'b0}}, o_adj});

    always_comb
    begin
        if (o_quot > O_HI)
        begin
            o_sat = O_HI[apcr_pkg::OUT_W-1:0];
        end
        else if (o_quot < O_LO)
        begin
            o_sat = O_LO[apcr_pkg::OUT_W-1:0];
        end
        else
        begin
            o_sat = o_quot[apcr_pkg::OUT_W-1:0];
        end
    end

    // Select write-back data
    always_comb
    begin
        case (ctl.wsel)
            apcr_pkg::WSEL_SAMPLE: wdata = x_reg;
            apcr_pkg::WSEL_STAGE:  wdata = y_sat;
            default:               wdata = '0;
        endcase
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (ctl.mul_en)
        begin
            prod_reg <= prod_next;
        end
        acc_reg <= acc_next;
        if (ctl.ld_sample)
        begin
            x_reg <= apcr_pkg::WORD_W'(sample_in);
        end
        else if (ctl.ld_stage)
        begin
            x_reg <= y_sat;
        end
        if (ctl.ld_base)
        begin
            xd_reg <= rdata;
            c_reg  <= c_next;
        end
        else if (ctl.ld_stage)
        begin
            xd_reg <= yd_reg;
        end
        if (ctl.ld_yd)
        begin
            yd_reg <= rdata;
        end
        if (ctl.ld_s)
        begin
            s_reg <= s_next;
        end
        if (ctl.ld_out)
        begin
            out_reg <= o_sat;
        end
    end

    assign sample_out = out_reg;

endmodule

// ----- rtl/apcr_ctrl.sv -----
// Sequencer: memory clear sweep, per-stage schedule, addresses and handshakes.
`timescale 1ns / 1ps

module apcr_ctrl
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          channel,
    output logic                          out_valid,
    input  logic                          out_ready,
    input  logic [apcr_pkg::DELAY_W-1:0]  delay_samples,
    input  logic [apcr_pkg::SCNT_W-1:0]   stage_count,
    input  logic [apcr_pkg::CCNT_W-1:0]   channel_count,
    output apcr_pkg::dp_ctl_t             ctl,
    output logic                          mem_we,
    output logic [apcr_pkg::ADDR_W-1:0]   mem_waddr,
    output logic                          mem_re,
    output logic [apcr_pkg::ADDR_W-1:0]   mem_raddr
);

    apcr_pkg::state_t                  state_reg;
    apcr_pkg::state_t                  state_next;
    logic [apcr_pkg::ADDR_W-1:0]       clr_reg;
    logic [apcr_pkg::ADDR_W-1:0]       clr_next;
    logic [apcr_pkg::POS_W-1:0]        wp_reg;
    logic [apcr_pkg::POS_W-1:0]        wp_next;
    logic [apcr_pkg::STAGE_W-1:0]      k_reg;
    logic [apcr_pkg::STAGE_W-1:0]      k_next;
    logic [apcr_pkg::CH_W-1:0]         ci_reg;
    logic [apcr_pkg::CH_W-1:0]         ci_next;
    logic                              adv_reg;
    logic                              adv_next;
    logic                              out_valid_reg;
    logic                              out_valid_next;

    logic                              accept;
    logic                              fire;
    logic [apcr_pkg::POS_W-1:0]        d_low;
    logic [apcr_pkg::POS_W-1:0]        rd_pos;
    logic [apcr_pkg::SCNT_W-1:0]       stage_m1;
    logic [apcr_pkg::STAGE_W-1:0]      last_stage;
    logic [apcr_pkg::CCNT_W-1:0]       nch_eff;
    logic [apcr_pkg::CCNT_W-1:0]       ch_plus;
    logic [apcr_pkg::STAGE_W-1:0]      k_inc;

    assign accept   = in_valid && in_ready;
    assign fire     = (state_reg == apcr_pkg::ST_ODONE) && (!out_valid_reg || out_ready);
    assign in_ready = (state_reg == apcr_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;
    assign k_inc    = k_reg + apcr_pkg::STAGE_W'(1);

    // Limit the delay; a full-length delay reads the current position
    always_comb
    begin
        if (delay_samples == '0)
        begin
            d_low = apcr_pkg::POS_W'(1);
        end
        else if (delay_samples >= apcr_pkg::MAX_DELAY)
        begin
            d_low = '0;
        end
        else
        begin
            d_low = delay_samples[apcr_pkg::POS_W-1:0];
        end
    end

    assign rd_pos = wp_reg - d_low;

    // Limit the stage count to the index of the last stage
    assign stage_m1 = stage_count - apcr_pkg::SCNT_W'(1);

    always_comb
    begin
        if (stage_count == '0)
        begin
            last_stage = '0;
        end
        else if (stage_count >= apcr_pkg::MAX_STAGES)
        begin
            last_stage = apcr_pkg::STAGE_W'(apcr_pkg::MAX_STAGES - 1);
        end
        else
        begin
            last_stage = stage_m1[apcr_pkg::STAGE_W-1:0];
        end
    end

    // Limit the channel count; the last channel of a frame advances the position
    always_comb
    begin
        if (channel_count == '0)
        begin
            nch_eff = apcr_pkg::CCNT_W'(1);
        end
        else if (channel_count > apcr_pkg::MAX_CHANNELS)
        begin
            nch_eff = apcr_pkg::CCNT_W'(apcr_pkg::MAX_CHANNELS);
        end
        else
        begin
            nch_eff = channel_count;
        end
    end

    assign ch_plus = apcr_pkg::CCNT_W'(channel) + apcr_pkg::CCNT_W'(1);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            apcr_pkg::ST_CLEAR:
            begin
                if (clr_reg == '1)
                begin
                    state_next = apcr_pkg::ST_IDLE;
                end
            end
            apcr_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = apcr_pkg::ST_LOAD;
                end
            end
            apcr_pkg::ST_LOAD:  state_next = apcr_pkg::ST_BASE;
            apcr_pkg::ST_BASE:
            begin
                if (last_stage == '0)
                begin
                    state_next = apcr_pkg::ST_OMUL;
                end
                else
                begin
                    state_next = apcr_pkg::ST_GY;
                end
            end
            apcr_pkg::ST_GY:    state_next = apcr_pkg::ST_SUM;
            apcr_pkg::ST_SUM:   state_next = apcr_pkg::ST_CLO;
            apcr_pkg::ST_CLO:   state_next = apcr_pkg::ST_CHI;
            apcr_pkg::ST_CHI:   state_next = apcr_pkg::ST_ACC;
            apcr_pkg::ST_ACC:   state_next = apcr_pkg::ST_WR;
            apcr_pkg::ST_WR:
            begin
                if (k_reg == last_stage)
                begin
                    state_next = apcr_pkg::ST_OMUL;
                end
                else
                begin
                    state_next = apcr_pkg::ST_GY;
                end
            end
            apcr_pkg::ST_OMUL:  state_next = apcr_pkg::ST_ODONE;
            apcr_pkg::ST_ODONE:
            begin
                if (fire)
                begin
                    state_next = apcr_pkg::ST_IDLE;
                end
            end
            default:            state_next = apcr_pkg::ST_CLEAR;
        endcase
    end

    // Datapath controls and memory port
    always_comb
    begin
        ctl       = '0;
        mem_we    = 1'b0;
        mem_waddr = {k_reg, ci_reg, wp_reg};
        mem_re    = 1'b0;
        mem_raddr = {k_inc, ci_reg, rd_pos};
        case (state_reg)
            apcr_pkg::ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                ctl.wsel  = apcr_pkg::WSEL_ZERO;
            end
            apcr_pkg::ST_IDLE:
            begin
                ctl.ld_sample = accept;
            end
            apcr_pkg::ST_LOAD:
            begin
                ctl.mul_en  = 1'b1;
                ctl.mul_sel = apcr_pkg::MUL_GG;
                mem_re      = 1'b1;
                mem_raddr   = {{apcr_pkg::STAGE_W{1'b0}}, ci_reg, rd_pos};
            end
            apcr_pkg::ST_BASE:
            begin
                ctl.ld_base = 1'b1;
                ctl.wsel    = apcr_pkg::WSEL_SAMPLE;
                mem_we      = 1'b1;
                mem_waddr   = {{apcr_pkg::STAGE_W{1'b0}}, ci_reg, wp_reg};
                mem_re      = (last_stage != '0);
                mem_raddr   = {apcr_pkg::STAGE_W'(1), ci_reg, rd_pos};
            end
            apcr_pkg::ST_GY:
            begin
                ctl.ld_yd   = 1'b1;
                ctl.mul_en  = 1'b1;
                ctl.mul_sel = apcr_pkg::MUL_GY;
            end
            apcr_pkg::ST_SUM:
            begin
                ctl.ld_s    = 1'b1;
                ctl.mul_en  = 1'b1;
                ctl.mul_sel = apcr_pkg::MUL_GX;
            end
            apcr_pkg::ST_CLO:
            begin
                ctl.acc_op  = apcr_pkg::ACC_LOAD_NGX;
                ctl.mul_en  = 1'b1;
                ctl.mul_sel = apcr_pkg::MUL_CLO;
            end
            apcr_pkg::ST_CHI:
            begin
                ctl.acc_op  = apcr_pkg::ACC_ADD_LO;
                ctl.mul_en  = 1'b1;
                ctl.mul_sel = apcr_pkg::MUL_CHI;
            end
            apcr_pkg::ST_ACC:
            begin
                ctl.acc_op = apcr_pkg::ACC_ADD_HI;
            end
            apcr_pkg::ST_WR:
            begin
                ctl.ld_stage = 1'b1;
                ctl.wsel     = apcr_pkg::WSEL_STAGE;
                mem_we       = 1'b1;
                mem_re       = (k_reg != last_stage);
            end
            apcr_pkg::ST_OMUL:
            begin
                ctl.mul_en  = 1'b1;
                ctl.mul_sel = apcr_pkg::MUL_OUT;
            end
            apcr_pkg::ST_ODONE:
            begin
                ctl.ld_out = fire;
            end
            default:
            begin
                ctl = '0;
            end
        endcase
    end

    // Counter and flag updates
    always_comb
    begin
        clr_next       = clr_reg;
        wp_next        = wp_reg;
        k_next         = k_reg;
        ci_next        = ci_reg;
        adv_next       = adv_reg;
        out_valid_next = out_valid_reg;
        if (state_reg == apcr_pkg::ST_CLEAR)
        begin
            clr_next = clr_reg + apcr_pkg::ADDR_W'(1);
        end
        if (accept)
        begin
            ci_next  = channel;
            adv_next = (ch_plus >= nch_eff);
        end
        if (state_reg == apcr_pkg::ST_BASE)
        begin
            k_next = apcr_pkg::STAGE_W'(1);
        end
        else if (state_reg == apcr_pkg::ST_WR)
        begin
            k_next = k_inc;
        end
        // Hold the result until taken; a new one replaces it in the same cycle
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (fire)
        begin
            out_valid_next = 1'b1;
            if (adv_reg)
            begin
                wp_next = wp_reg + apcr_pkg::POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= apcr_pkg::ST_CLEAR;
            clr_reg       <= '0;
            wp_reg        <= '0;
            k_reg         <= '0;
            ci_reg        <= '0;
            adv_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            wp_reg        <= wp_next;
            k_reg         <= k_next;
            ci_reg        <= ci_next;
            adv_reg       <= adv_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- rtl/allpass_cascade_reverb.sv -----
// Top level of the allpass cascade reverb: configuration registers and unit wiring.
`timescale 1ns / 1ps

// Channel  | Signals                                   | Transaction
// ---------+-------------------------------------------+-------------------------------
// input    | in_valid, in_ready, sample_in, channel    | in_valid & in_ready at clk
// output   | out_valid, out_ready, sample_out          | out_valid & out_ready at clk
// config   | cfg_write, cfg_index, cfg_data            | cfg_write at clk, no wait
//
// A sample runs from acceptance through ST_LOAD and ST_BASE, then ST_GY, ST_SUM, ST_CLO,
// ST_CHI, ST_ACC and ST_WR for each stage after the first, then ST_OMUL and ST_ODONE into
// the result register; in_ready returns as that register is loaded.
// The schedule comes from the single shared 25x18 multiplier: four products per stage,
// then an accumulate step and a write-back step.
// After reset all 32768 words of the delay store are swept to zero, one word a cycle;
// in_ready stays low during the sweep.
// A held result does not block acceptance; a finished sample waits until it is taken.

module allpass_cascade_reverb
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [apcr_pkg::SAMPLE_BITS-1:0] sample_in,
    input  logic                               channel,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [apcr_pkg::OUT_W-1:0]  sample_out,
    input  logic                               cfg_write,
    input  logic [apcr_pkg::IDX_W-1:0]         cfg_index,
    input  logic [apcr_pkg::CFG_W-1:0]         cfg_data
);

    logic [apcr_pkg::DELAY_W-1:0]  delay_samples_reg;
    logic [apcr_pkg::SCNT_W-1:0]   stage_count_reg;
    logic [apcr_pkg::GAIN_W-1:0]   decay_gain_reg;
    logic [apcr_pkg::OGAIN_W-1:0]  output_gain_reg;
    logic [apcr_pkg::CCNT_W-1:0]   channel_count_reg;

    apcr_pkg::dp_ctl_t             ctl;
    logic                          mem_we;
    logic [apcr_pkg::ADDR_W-1:0]   mem_waddr;
    logic                          mem_re;
    logic [apcr_pkg::ADDR_W-1:0]   mem_raddr;
    apcr_pkg::word_t               mem_wdata;
    apcr_pkg::word_t               mem_rdata;

    // Configuration registers; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_samples_reg <= apcr_pkg::DELAY_RST;
            stage_count_reg   <= apcr_pkg::STAGES_RST;
            decay_gain_reg    <= apcr_pkg::DECAY_RST;
            output_gain_reg   <= apcr_pkg::OGAIN_RST;
            channel_count_reg <= apcr_pkg::CHANS_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                apcr_pkg::REG_DELAY:
                    delay_samples_reg <= cfg_data[apcr_pkg::DELAY_W-1:0];
                apcr_pkg::REG_STAGES:
                    stage_count_reg <= cfg_data[apcr_pkg::SCNT_W-1:0];
                apcr_pkg::REG_DECAY:
                    decay_gain_reg <= cfg_data[apcr_pkg::GAIN_W-1:0];
                apcr_pkg::REG_OGAIN:
                    output_gain_reg <= cfg_data[apcr_pkg::OGAIN_W-1:0];
                apcr_pkg::REG_CHANNELS:
                    channel_count_reg <= cfg_data[apcr_pkg::CCNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    apcr_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .channel       (channel),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .delay_samples (delay_samples_reg),
        .stage_count   (stage_count_reg),
        .channel_count (channel_count_reg),
        .ctl           (ctl),
        .mem_we        (mem_we),
        .mem_waddr     (mem_waddr),
        .mem_re        (mem_re),
        .mem_raddr     (mem_raddr)
    );

    apcr_dp u_dp
    (
        .clk         (clk),
        .ctl         (ctl),
        .sample_in   (sample_in),
        .decay_gain  (decay_gain_reg),
        .output_gain (output_gain_reg),
        .rdata       (mem_rdata),
        .wdata       (mem_wdata),
        .sample_out  (sample_out)
    );

    apcr_delay_mem u_mem
    (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

`ifndef NO_ASSERTIONS
    // One sample at a time: the input closes right after a transaction
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted while a sample is in work");

    // Stage reads and write-back never hit the same word in one cycle
    a_mem_no_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
        else $error("delay store read and write at the same address");

    // A new result only appears when the sequencer loads the output register
    a_result_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(ctl.ld_out))
        else $error("result valid without an output load");

    // The input stays closed during the clear sweep
    a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && (ctl.wsel == apcr_pkg::WSEL_ZERO)) |-> !in_ready)
        else $error("input open while the delay store is being cleared");
`endif

endmodule

// ----- sim/tb_allpass_cascade_reverb.sv -----
// Self-checking testbench of the allpass cascade reverb, with an in-bench predictor.
`timescale 1ns / 1ps

module tb_allpass_cascade_reverb;

    localparam int     WATCHDOG_LIMIT = 150000;
    localparam int     REPORT_LIMIT   = 10;
    localparam int     SETTLE_CYCLES  = 100;
    localparam int     RANDOM_PHASES  = 8;
    localparam int     DECAY_MAX      = (1 << apcr_pkg::GAIN_W) - 1;
    localparam int     OGAIN_MAX      = (1 << apcr_pkg::OGAIN_W) - 1;
    localparam longint STAGE_HI       = (longint'(1) << (apcr_pkg::WORD_W - 1)) - 1;
    localparam longint STAGE_LO       = -(longint'(1) << (apcr_pkg::WORD_W - 1));
    localparam longint OUT_HI         = (longint'(1) << (apcr_pkg::OUT_W - 1)) - 1;
    localparam longint OUT_LO         = -(longint'(1) << (apcr_pkg::OUT_W - 1));
    localparam longint FRAC_ONE       = longint'(1) << apcr_pkg::FRAC_W;
    localparam longint UNITY_SQ       = longint'(1) << (2 * apcr_pkg::FRAC_W);
    localparam longint OUT_ONE        = longint'(1) << apcr_pkg::OSHIFT;
    localparam logic signed [apcr_pkg::SAMPLE_BITS-1:0] SAMPLE_HI =
        {1'b0, {(apcr_pkg::SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [apcr_pkg::SAMPLE_BITS-1:0] SAMPLE_LO =
        {1'b1, {(apcr_pkg::SAMPLE_BITS-1){1'b0}}};

    logic                                    clk = 1'b0;
    logic                                    rst_n;
    logic                                    in_valid;
    logic                                    in_ready;
    logic signed [apcr_pkg::SAMPLE_BITS-1:0] sample_in;
    logic                                    channel;
    logic                                    out_valid;
    logic                                    out_ready;
    logic signed [apcr_pkg::OUT_W-1:0]       sample_out;
    logic                                    cfg_write;
    logic [apcr_pkg::IDX_W-1:0]              cfg_index;
    logic [apcr_pkg::CFG_W-1:0]              cfg_data;

    // Predictor copy of the registers and of the delay store
    logic [apcr_pkg::DELAY_W-1:0]  cfg_delay;
    logic [apcr_pkg::SCNT_W-1:0]   cfg_stages;
    logic [apcr_pkg::GAIN_W-1:0]   cfg_decay;
    logic [apcr_pkg::OGAIN_W-1:0]  cfg_ogain;
    logic [apcr_pkg::CCNT_W-1:0]   cfg_chans;
    int echo_mem [apcr_pkg::MAX_STAGES][apcr_pkg::MAX_CHANNELS][apcr_pkg::MAX_DELAY];
    int write_pos;

    logic signed [apcr_pkg::OUT_W-1:0] expected_q [$];

    int mismatch_count;
    int idle_cycles;
    int burst_left;
    int gap_max;
    int stall_pct;
    int stall_len;
    int ready_hold;

    always #1 clk = ~clk;

    allpass_cascade_reverb uut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .sample_in  (sample_in),
        .channel    (channel),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sample_out (sample_out),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    function automatic int clamp_count(int value, int hi);
        if (value < 1)
            return 1;
        if (value > hi)
            return hi;
        return value;
    endfunction

    function automatic longint saturate(longint value, longint lo, longint hi);
        if (value < lo)
            return lo;
        if (value > hi)
            return hi;
        return value;
    endfunction

    // One allpass stage: x is the new input, xd and yd the delayed input and output
    function automatic int allpass_stage(int x, int xd, int yd, longint g);
        longint c;
        longint s;
        longint t;
        c = (UNITY_SQ - g * g) / FRAC_ONE;
        s = longint'(xd) * FRAC_ONE + g * longint'(yd);
        t = c * s - g * longint'(x) * FRAC_ONE;
        return int'(saturate(t / UNITY_SQ, STAGE_LO, STAGE_HI));
    endfunction

    // Run one sample through the cascade, update the store and return the output
    function automatic logic signed [apcr_pkg::OUT_W-1:0] reverb_predict(
        input logic signed [apcr_pkg::SAMPLE_BITS-1:0] smp,
        input logic                                    ch
    );
        int     prior [apcr_pkg::MAX_STAGES];
        int     d;
        int     n;
        int     nch;
        int     ci;
        int     rd;
        int     x;
        longint g;
        longint o;
        d   = clamp_count(int'(cfg_delay), apcr_pkg::MAX_DELAY);
        n   = clamp_count(int'(cfg_stages), apcr_pkg::MAX_STAGES);
        nch = clamp_count(int'(cfg_chans), apcr_pkg::MAX_CHANNELS);
        ci  = (int'(ch) < apcr_pkg::MAX_CHANNELS) ? int'(ch) : apcr_pkg::MAX_CHANNELS - 1;
        rd  = (write_pos + apcr_pkg::MAX_DELAY - d) % apcr_pkg::MAX_DELAY;
        g   = longint'(cfg_decay);
        // read every delayed word before writing the current position
        for (int k = 0; k < n; k++)
            prior[k] = echo_mem[k][ci][rd];
        x = smp;
        echo_mem[0][ci][write_pos] = x;
        for (int k = 1; k < n; k++)
        begin
            x = allpass_stage(x, prior[k-1], prior[k], g);
            echo_mem[k][ci][write_pos] = x;
        end
        o = saturate((longint'(x) * longint'(cfg_ogain)) / OUT_ONE, OUT_LO, OUT_HI);
        if (int'(ch) + 1 >= nch)
            write_pos = (write_pos + 1) % apcr_pkg::MAX_DELAY;
        return o[apcr_pkg::OUT_W-1:0];
    endfunction

    function automatic void note_mismatch(string what, logic [apcr_pkg::OUT_W-1:0] want,
                                          logic [apcr_pkg::OUT_W-1:0] got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: %s: expected %0d, got %0d", $realtime, what,
                     $signed(want), $signed(got));
    endfunction

    // Predict on every accepted input transaction
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            expected_q.push_back(reverb_predict(sample_in, channel));
    end

    // Compare every accepted output transaction with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_q.size() == 0)
                note_mismatch("result with nothing pending", 'x, sample_out);
            else
            begin
                if (sample_out !== expected_q[0])
                    note_mismatch("sample_out", expected_q[0], sample_out);
                expected_q.delete(0);
            end
        end
    end

    // Stall the receiver in stretches of random length
    always @(posedge clk)
    begin
        if (ready_hold == 0)
        begin
            out_ready  <= ($urandom_range(99, 0) >= stall_pct);
            ready_hold <= $urandom_range(stall_len, 0);
        end
        else
            ready_hold <= ready_hold - 1;
    end

    // End the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic write_reg(input logic [apcr_pkg::IDX_W-1:0] idx,
                             input logic [apcr_pkg::CFG_W-1:0] data);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            apcr_pkg::REG_DELAY:    cfg_delay  = data[apcr_pkg::DELAY_W-1:0];
            apcr_pkg::REG_STAGES:   cfg_stages = data[apcr_pkg::SCNT_W-1:0];
            apcr_pkg::REG_DECAY:    cfg_decay  = data[apcr_pkg::GAIN_W-1:0];
            apcr_pkg::REG_OGAIN:    cfg_ogain  = data[apcr_pkg::OGAIN_W-1:0];
            apcr_pkg::REG_CHANNELS: cfg_chans  = data[apcr_pkg::CCNT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic configure(input int delay, input int stages, input int decay,
                             input int ogain, input int chans);
        write_reg(apcr_pkg::REG_DELAY,    apcr_pkg::CFG_W'(delay));
        write_reg(apcr_pkg::REG_STAGES,   apcr_pkg::CFG_W'(stages));
        write_reg(apcr_pkg::REG_DECAY,    apcr_pkg::CFG_W'(decay));
        write_reg(apcr_pkg::REG_OGAIN,    apcr_pkg::CFG_W'(ogain));
        write_reg(apcr_pkg::REG_CHANNELS, apcr_pkg::CFG_W'(chans));
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // Offer one sample; start a new burst after a random gap when the last one ran out
    task automatic send_sample(input logic signed [apcr_pkg::SAMPLE_BITS-1:0] smp,
                               input logic ch);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(16, 1);
            gap = (gap_max == 0) ? 0 : $urandom_range(gap_max, 0);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid  <= 1'b1;
        sample_in <= smp;
        channel   <= ch;
        @(posedge clk);
        while (in_ready !== 1'b1)
            @(posedge clk);
    endtask

    // Drop valid and wait for every pending result
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Reset registers over a zeroed store; channel 1 falls outside a one-channel frame
    task automatic test_reset_state();
        send_sample(SAMPLE_HI, 1'b0);
        send_sample(SAMPLE_LO, 1'b0);
        send_sample('0, 1'b0);
        send_sample('1, 1'b1);
        send_sample(16'sd1, 1'b0);
        wait_idle();
    endtask

    // Shortest delay, all stages, largest coefficient and gain, two channels
    task automatic test_register_extremes();
        configure(1, apcr_pkg::MAX_STAGES, DECAY_MAX, OGAIN_MAX, apcr_pkg::MAX_CHANNELS);
        for (int i = 0; i < 8; i++)
            send_sample((i % 4 < 2) ? SAMPLE_HI : SAMPLE_LO, i[0]);
        wait_idle();
    endtask

    // Zero and oversized register values, and writes to indexes beyond the list
    task automatic test_register_limits();
        configure(0, 0, 0, 0, 0);
        send_sample(SAMPLE_HI, 1'b0);
        send_sample(SAMPLE_LO, 1'b1);
        send_sample(16'sh5555, 1'b0);
        send_sample(-16'sh5556, 1'b0);
        wait_idle();
        for (int i = int'(apcr_pkg::REG_CHANNELS) + 1; i < (1 << apcr_pkg::IDX_W); i++)
            write_reg(apcr_pkg::IDX_W'(i), '1);
        configure((1 << apcr_pkg::DELAY_W) - 1, (1 << apcr_pkg::SCNT_W) - 1, 1,
                  apcr_pkg::OGAIN_RST, (1 << apcr_pkg::CCNT_W) - 1);
        send_sample(SAMPLE_HI, 1'b0);
        send_sample(SAMPLE_LO, 1'b1);
        send_sample('1, 1'b1);
        send_sample(SAMPLE_HI, 1'b0);
        send_sample(16'sd1, 1'b1);
        wait_idle();
    endtask

    // Random settings per phase; mostly well-formed frames with random samples
    task automatic test_random_phases();
        int sel;
        int delay;
        int stages;
        int decay;
        int ogain;
        int chans;
        int eff_ch;
        int slot;
        int items;
        logic signed [apcr_pkg::SAMPLE_BITS-1:0] smp;
        logic ch;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            sel = $urandom_range(99, 0);
            if (sel < 70)
                delay = $urandom_range(24, 1);
            else if (sel < 85)
                delay = $urandom_range(apcr_pkg::MAX_DELAY, 25);
            else
                case ($urandom_range(4, 0))
                    0: delay = 0;
                    1: delay = 1;
                    2: delay = apcr_pkg::MAX_DELAY - 1;
                    3: delay = apcr_pkg::MAX_DELAY;
                    default: delay = (1 << apcr_pkg::DELAY_W) - 1;
                endcase
            stages = ($urandom_range(99, 0) < 85)
                   ? $urandom_range(apcr_pkg::MAX_STAGES, 1)
                   : $urandom_range((1 << apcr_pkg::SCNT_W) - 1, 0);
            sel = $urandom_range(99, 0);
            if (sel < 10)
                decay = 0;
            else if (sel < 20)
                decay = DECAY_MAX;
            else
                decay = $urandom_range(DECAY_MAX, 0);
            ogain = ($urandom_range(99, 0) < 20) ? int'(apcr_pkg::OGAIN_RST)
                                                 : $urandom_range(OGAIN_MAX, 0);
            chans = ($urandom_range(99, 0) < 85)
                  ? $urandom_range(apcr_pkg::MAX_CHANNELS, 1)
                  : $urandom_range(1, 0) * ((1 << apcr_pkg::CCNT_W) - 1);
            // set stray upper data bits that the registers must drop
            write_reg(apcr_pkg::REG_DELAY, apcr_pkg::CFG_W'(delay)
                      | (apcr_pkg::CFG_W'($urandom()) << apcr_pkg::DELAY_W));
            write_reg(apcr_pkg::REG_STAGES, apcr_pkg::CFG_W'(stages)
                      | (apcr_pkg::CFG_W'($urandom()) << apcr_pkg::SCNT_W));
            write_reg(apcr_pkg::REG_DECAY, apcr_pkg::CFG_W'(decay)
                      | (apcr_pkg::CFG_W'($urandom()) << apcr_pkg::GAIN_W));
            write_reg(apcr_pkg::REG_OGAIN, apcr_pkg::CFG_W'(ogain));
            write_reg(apcr_pkg::REG_CHANNELS, apcr_pkg::CFG_W'(chans)
                      | (apcr_pkg::CFG_W'($urandom()) << apcr_pkg::CCNT_W));
            @(posedge clk);
            cfg_write <= 1'b0;

            // every fourth phase runs without idling on either side
            if (phase % 4 == 0)
            begin
                gap_max   = 0;
                stall_pct = 0;
                stall_len = 0;
            end
            else
            begin
                gap_max   = $urandom_range(40, 1);
                stall_pct = $urandom_range(85, 10);
                stall_len = $urandom_range(20, 0);
            end

            eff_ch = clamp_count(chans, apcr_pkg::MAX_CHANNELS);
            slot   = 0;
            items  = $urandom_range(100, 70);
            for (int i = 0; i < items; i++)
            begin
                if ($urandom_range(99, 0) < 80)
                begin
                    ch   = slot[0];
                    slot = (slot + 1) % eff_ch;
                end
                else
                    ch = 1'($urandom_range(1, 0));
                sel = $urandom_range(99, 0);
                if (sel < 60)
                    smp = apcr_pkg::SAMPLE_BITS'($urandom());
                else if (sel < 85)
                    smp = apcr_pkg::SAMPLE_BITS'(int'($urandom_range(64, 0)) - 32);
                else
                    case ($urandom_range(3, 0))
                        0: smp = SAMPLE_HI;
                        1: smp = SAMPLE_LO;
                        2: smp = '0;
                        default: smp = '1;
                    endcase
                send_sample(smp, ch);
            end
            wait_idle();
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        sample_in  = '0;
        channel    = 1'b0;
        out_ready  = 1'b0;
        cfg_write  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        cfg_delay  = apcr_pkg::DELAY_RST;
        cfg_stages = apcr_pkg::STAGES_RST;
        cfg_decay  = apcr_pkg::DECAY_RST;
        cfg_ogain  = apcr_pkg::OGAIN_RST;
        cfg_chans  = apcr_pkg::CHANS_RST;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_register_extremes();
        test_register_limits();
        test_random_phases();

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
